// ===== src/table_tone_generator_assert.svh =====
// Assertion macros shared by the tone generator RTL.
`ifndef TABLE_TONE_GENERATOR_ASSERT_SVH
`define TABLE_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication, held off while reset is low.
`define TTG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define TTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ttg_pkg.sv =====
// Types, codes, constants and tables for the table tone generator.
`timescale 1ns / 1ps
package ttg_pkg;

    localparam int TABLE_DEPTH_DEF = 512;
    localparam int SAMPLE_RATE_HZ  = 15620;
    localparam int NUM_SEL         = 11;
    localparam int SEL_MAX         = 10;
    localparam int FULL_SCALE      = 20480;

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 9;
    localparam int SAMPLE_W = 12;
    localparam int STATUS_W = 2;
    localparam int SEL_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int DIVISOR_W = 12;
    localparam int DIVIDEND_W = 15;

    typedef logic [FUNC_W-1:0]    t_func;
    typedef logic [INDEX_W-1:0]   t_index;
    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [SEL_W-1:0]     t_sel;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [DIVISOR_W-1:0] t_divisor;

    localparam t_func FN_TICK  = 2'd0;
    localparam t_func FN_START = 2'd1;
    localparam t_func FN_STOP  = 2'd2;
    localparam t_func FN_WRITE = 2'd3;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_HALTED = 2'd1;
    localparam t_status ST_ACTIVE = 2'd2;

    localparam t_cfg_idx REG_TONE   = 1'd0;
    localparam t_cfg_idx REG_VOLUME = 1'd1;

    localparam t_sel    SEL_RESET = 4'd5;
    localparam t_sample MIDSCALE  = 12'd2048;

    localparam int TONE_HZ [NUM_SEL] = '{550, 600, 650, 700, 750, 800,
                                         850, 900, 950, 1000, 1050};

    // Divisor is full scale over the logarithmic volume step.
    localparam t_divisor VOL_DIV [NUM_SEL] = '{
        t_divisor'(FULL_SCALE / 10),  t_divisor'(FULL_SCALE / 17),
        t_divisor'(FULL_SCALE / 29),  t_divisor'(FULL_SCALE / 49),
        t_divisor'(FULL_SCALE / 84),  t_divisor'(FULL_SCALE / 143),
        t_divisor'(FULL_SCALE / 244), t_divisor'(FULL_SCALE / 415),
        t_divisor'(FULL_SCALE / 706), t_divisor'(FULL_SCALE / 1203),
        t_divisor'(FULL_SCALE / 2048)};

    // Phase increment per tick for one tone, worked out at elaboration.
    function automatic int tone_step(int sel, int depth);
        return (TONE_HZ[sel] * depth) / SAMPLE_RATE_HZ;
    endfunction

    function automatic t_sel clamp_sel(t_sel s);
        return (s > t_sel'(SEL_MAX)) ? t_sel'(SEL_MAX) : s;
    endfunction

endpackage

// ===== src/ttg_if.sv =====
// Handshake channels of the table tone generator: command, result and register write.
`timescale 1ns / 1ps
interface ttg_cmd_if;
    import ttg_pkg::*;
    logic    valid;
    logic    ready;
    t_func   func;
    t_index  wave_index;
    t_sample wave_value;
    modport source (output valid, output func, output wave_index, output wave_value,
                    input ready);
    modport sink   (input valid, input func, input wave_index, input wave_value,
                    output ready);
endinterface

interface ttg_res_if;
    import ttg_pkg::*;
    logic    valid;
    logic    ready;
    t_sample dac_value;
    logic    dac_write;
    t_status status;
    logic    running;
    modport source (output valid, output dac_value, output dac_write, output status,
                    output running, input ready);
    modport sink   (input valid, input dac_value, input dac_write, input status,
                    input running, output ready);
endinterface

interface ttg_cfg_if;
    import ttg_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx reg_index;
    t_sel     reg_data;
    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== src/table_tone_generator.sv =====
// Table tone generator: wave store, phase accumulator and volume scaler.
// Path: a scaled tick goes from command beat through store read, a 15-step serial
// divide and hand-over to the result beat; every other command, a midscale tick
// too, skips the read and the divide.
// Flow: one command at a time; a scaled tick holds the command side while the
// bit-per-cycle divider runs; the result register frees the command side early.
// Reset: phase 0, tone stopped and settled, both selectors 5; store is not cleared.
`timescale 1ns / 1ps
`include "table_tone_generator_assert.svh"
module table_tone_generator #(
    parameter int TABLE_DEPTH = ttg_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttg_cmd_if.sink     i_cmd,
    ttg_cfg_if.sink     i_cfg,
    ttg_res_if.source   o_res
);
    import ttg_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(DIVIDEND_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [AW-1:0] step_tab [NUM_SEL];

    for (genvar g = 0; g < NUM_SEL; g++) begin : g_step
        assign step_tab[g] = AW'(tone_step(g, TABLE_DEPTH));
    end

    logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];

    logic [1:0]            r_state, n_state;
    logic [AW-1:0]         r_phase, n_phase;
    logic                  r_enabled, n_enabled;
    logic                  r_settled, n_settled;
    t_sel                  r_tone, r_volume;
    t_sample               r_rdata;
    logic                  r_neg;
    t_divisor              r_div;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W:0]    r_rem;
    logic [CNT_W-1:0]      r_cnt;
    t_sample               r_res_value, n_res_value;
    logic                  r_res_write, n_res_write;
    t_status               r_res_status, n_res_status;
    logic                  r_res_running, n_res_running;
    logic                  r_out_valid;
    t_sample               r_out_value;
    logic                  r_out_write;
    t_status               r_out_status;
    logic                  r_out_running;

    logic                  cmd_acc;
    logic                  is_start;
    logic                  cur_en;
    logic [AW-1:0]         cur_phase;
    logic [AW:0]           next_phase;
    logic                  wrap;
    logic                  wr_en;
    logic [AW-1:0]         rd_addr;
    logic                  load_out;
    logic                  rd_neg;
    logic [SAMPLE_W-1:0]   rd_mag;
    logic [DIVISOR_W:0]    shifted;
    logic                  ge;
    t_sample               q_low;

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign load_out    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // A start sounds from phase zero with the tone already enabled.
    assign is_start   = (i_cmd.func == FN_START);
    assign cur_en     = is_start ? 1'b1 : r_enabled;
    assign cur_phase  = is_start ? '0 : r_phase;
    assign next_phase = {1'b0, cur_phase} + {1'b0, step_tab[clamp_sel(r_tone)]};
    assign wrap       = next_phase >= (AW+1)'(TABLE_DEPTH);
    assign rd_addr    = cur_phase;
    assign wr_en      = cmd_acc && (i_cmd.func == FN_WRITE)
                        && (32'(i_cmd.wave_index) < 32'(TABLE_DEPTH));

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_enabled     = r_enabled;
        n_settled     = r_settled;
        n_res_value   = r_res_value;
        n_res_write   = r_res_write;
        n_res_status  = r_res_status;
        n_res_running = r_res_running;
        case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_state       = S_DONE;
                    n_res_value   = '0;
                    n_res_write   = 1'b0;
                    n_res_status  = ST_OK;
                    n_res_running = r_enabled;
                    case (i_cmd.func)
                        FN_TICK, FN_START: begin
                            if (is_start && r_enabled) begin
                                n_res_status = ST_ACTIVE;
                            end else if (!is_start && !r_enabled && r_settled) begin
                                n_res_status = ST_HALTED;
                            end else begin
                                n_enabled     = cur_en;
                                n_res_running = cur_en;
                                n_res_write   = 1'b1;
                                n_settled     = is_start ? 1'b0 : r_settled;
                                n_phase       = wrap ? AW'(next_phase - (AW+1)'(TABLE_DEPTH))
                                                     : next_phase[AW-1:0];
                                if (wrap && !cur_en) begin
                                    // finish the stopped cycle on midscale
                                    n_settled   = 1'b1;
                                    n_res_value = MIDSCALE;
                                end else begin
                                    n_state = S_READ;
                                end
                            end
                        end
                        FN_STOP: begin
                            n_enabled     = 1'b0;
                            n_res_running = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state     = S_DONE;
                    n_res_value = r_neg ? MIDSCALE - q_low : MIDSCALE + q_low;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Quotient of a full-scale point is 2048, which still fits the sample width.
    // Take it with the last divide step folded in.
    assign q_low = {r_quo[SAMPLE_W-2:0], ge};

    // Split the point into sign and magnitude around midscale.
    assign rd_neg = !r_rdata[SAMPLE_W-1];
    assign rd_mag = rd_neg ? MIDSCALE - r_rdata : r_rdata - MIDSCALE;

    // One restoring divide step per cycle.
    assign shifted = {r_rem[DIVISOR_W-1:0], r_quo[DIVIDEND_W-1]};
    assign ge      = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(i_cmd.wave_index)] <= i_cmd.wave_value;
        end
        if (cmd_acc) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_value   <= n_res_value;
        r_res_write   <= n_res_write;
        r_res_status  <= n_res_status;
        r_res_running <= n_res_running;
        if (r_state == S_READ) begin
            r_neg <= rd_neg;
            r_div <= VOL_DIV[clamp_sel(r_volume)];
            r_rem <= '0;
            r_quo <= DIVIDEND_W'({rd_mag, 3'b000}) + DIVIDEND_W'({rd_mag, 1'b0});
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? shifted - {1'b0, r_div} : shifted;
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
        if (load_out) begin
            r_out_value   <= r_res_value;
            r_out_write   <= r_res_write;
            r_out_status  <= r_res_status;
            r_out_running <= r_res_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_enabled   <= 1'b0;
            r_settled   <= 1'b1;
            r_tone      <= SEL_RESET;
            r_volume    <= SEL_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_enabled <= n_enabled;
            r_settled <= n_settled;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    REG_TONE:   r_tone   <= i_cfg.reg_data;
                    REG_VOLUME: r_volume <= i_cfg.reg_data;
                    default: ;
                endcase
            end
            if (r_state == S_READ) begin
                r_cnt <= CNT_W'(DIVIDEND_W - 1);
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.dac_value = r_out_value;
    assign o_res.dac_write = r_out_write;
    assign o_res.status    = r_out_status;
    assign o_res.running   = r_out_running;

    `TTG_ASSERT_NOW(a_silent_zero, i_clk, i_rst_n,
        o_res.valid && !o_res.dac_write, o_res.dac_value == '0,
        "result without a sample carries a non-zero value")
    `TTG_ASSERT_NOW(a_active_running, i_clk, i_rst_n,
        o_res.valid && (o_res.status == ST_ACTIVE), o_res.running,
        "already-active status reported while stopped")
    `TTG_ASSERT_NOW(a_halted_quiet, i_clk, i_rst_n,
        o_res.valid && (o_res.status == ST_HALTED), !o_res.running && !o_res.dac_write,
        "halted status with a sample or a running tone")
    `TTG_ASSERT_NEXT(a_start_arms, i_clk, i_rst_n,
        cmd_acc && is_start && !r_enabled, r_enabled && !r_settled,
        "start from stopped did not enable the tone")

endmodule
